// File: sv/mapd_pkg.sv
// Package: shared constants, types and helpers of the MFM adaptive PLL decoder.
package mapd_pkg;

    localparam int MAX_HALF_CLOCKS_DEF = 16;
    localparam int FLUX_BITS_DEF       = 16;
    localparam int FRAC_BITS_DEF       = 8;

    localparam int EST_W      = 24;
    localparam int ALPHA_W    = 9;
    localparam int IDX_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [EST_W-1:0]   EST_MAX       = 24'hFFFFFF;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;
    localparam logic [EST_W-1:0]   NOMINAL_RESET = 24'd20480;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 9'd128;
    localparam int                 ROUND_HALF    = 128;
    localparam int                 BLEND_SHIFT   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 8'd1;

    typedef enum logic [1:0] {
        DIV_HOLD,
        DIV_LOAD,
        DIV_STEP
    } t_div_cmd;

    // Half-clock estimate after a nominal clock reload, never below one LSB.
    function automatic logic [EST_W-1:0] est_from_nominal(input logic [EST_W-1:0] nom);
        logic [EST_W-1:0] half;
        half = nom >> 1;
        return (half == '0) ? EST_W'(1) : half;
    endfunction

endpackage

// File: sv/mapd_if.sv
// Interfaces: flux interval input, decoded bit output and configuration write channels.
interface mapd_in_if #(
    parameter int FLUX_BITS = mapd_pkg::FLUX_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [FLUX_BITS-1:0] flux_interval;

    modport source (output valid, output flux_interval, input ready);
    modport sink   (input valid, input flux_interval, output ready);
endinterface

interface mapd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       bit_res;
    logic                       last;
    logic [mapd_pkg::IDX_W-1:0] interval_index;

    modport source (output valid, output bit_res, output last, output interval_index,
                    input ready);
    modport sink   (input valid, input bit_res, input last, input interval_index,
                    output ready);
endinterface

interface mapd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mapd_pkg::CFG_IDX_W-1:0]  index;
    logic [mapd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mapd_divider.sv
// Shared restoring divider: one quotient bit per step, remainder preload for short quotients.
module mapd_divider #(
    parameter int RW = 26,
    parameter int FW = 24,
    parameter int DW = 25
) (
    input  logic               i_clk,
    input  mapd_pkg::t_div_cmd i_cmd,
    input  logic [RW-1:0]      i_rem_load,
    input  logic [FW-1:0]      i_shift_load,
    input  logic [DW-1:0]      i_divisor,
    output logic               o_ge,
    output logic [FW-1:0]      o_quo
);

    logic [RW-1:0] r_rem;
    logic [FW-1:0] r_shift;
    logic [FW-1:0] r_quo;

    logic [RW:0] w_trial;
    logic [RW:0] w_dext;
    logic [RW:0] w_diff;
    logic        w_ge_step;

    assign w_trial   = {r_rem, r_shift[FW-1]};
    assign w_dext    = (RW+1)'(i_divisor);
    assign w_ge_step = (w_trial >= w_dext);
    assign w_diff    = w_trial - w_dext;

    // Remainder against divisor as it stands: flags an oversized quotient after a preload
    assign o_ge  = (r_rem >= RW'(i_divisor));
    assign o_quo = r_quo;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            mapd_pkg::DIV_LOAD: begin
                r_rem   <= i_rem_load;
                r_shift <= i_shift_load;
                r_quo   <= '0;
            end
            mapd_pkg::DIV_STEP: begin
                r_rem   <= w_ge_step ? w_diff[RW-1:0] : w_trial[RW-1:0];
                r_shift <= {r_shift[FW-2:0], 1'b0};
                r_quo   <= {r_quo[FW-2:0], w_ge_step};
            end
            default: begin
                r_rem   <= r_rem;
                r_shift <= r_shift;
                r_quo   <= r_quo;
            end
        endcase
    end

endmodule

// File: sv/mapd_blend.sv
// Estimate blend: registered products, then round, clamp to 0.75..2.25 of old estimate.
module mapd_blend #(
    parameter int FW = 24
) (
    input  logic                         i_clk,
    input  logic [mapd_pkg::EST_W-1:0]   i_est,
    input  logic [FW-1:0]                i_m,
    input  logic [mapd_pkg::ALPHA_W-1:0] i_alpha,
    output logic [mapd_pkg::EST_W-1:0]   o_est_next
);

    localparam int EW  = mapd_pkg::EST_W;
    localparam int AW  = mapd_pkg::ALPHA_W;
    localparam int P1W = EW + AW;
    localparam int P2W = FW + AW;
    localparam int SW  = ((P2W > P1W) ? P2W : P1W) + 1;
    localparam int PW  = SW - mapd_pkg::BLEND_SHIFT;
    localparam int HW  = EW + 2;
    localparam int CW  = (PW > HW) ? PW : HW;

    logic [AW-1:0]  w_a;
    logic [AW-1:0]  w_inv;
    logic [P1W-1:0] r_prod1;
    logic [P2W-1:0] r_prod2;
    logic [SW-1:0]  w_sum;
    logic [HW+1:0]  w_9e;
    logic [HW-1:0]  w_3e;
    logic [CW-1:0]  w_p;
    logic [CW-1:0]  w_hi;
    logic [CW-1:0]  w_lo;
    logic [CW-1:0]  w_p1;
    logic [CW-1:0]  w_p2;

    assign w_a   = (i_alpha > mapd_pkg::ALPHA_ONE) ? mapd_pkg::ALPHA_ONE : i_alpha;
    assign w_inv = mapd_pkg::ALPHA_ONE - w_a;

    always_ff @(posedge i_clk) begin
        r_prod1 <= P1W'(i_est) * P1W'(w_inv);
        r_prod2 <= P2W'(i_m) * P2W'(w_a);
    end

    assign w_sum = SW'(r_prod1) + SW'(r_prod2) + SW'(mapd_pkg::ROUND_HALF);
    assign w_p   = CW'(w_sum[SW-1:mapd_pkg::BLEND_SHIFT]);

    // 9e/4 and 3e/4, floored
    assign w_9e = ((HW+2)'(i_est) << 3) + (HW+2)'(i_est);
    assign w_3e = (HW'(i_est) << 1) + HW'(i_est);
    assign w_hi = CW'(w_9e[HW+1:2]);
    assign w_lo = CW'(w_3e[HW-1:2]);

    always_comb begin
        w_p1 = (w_p > w_hi) ? w_hi : w_p;
        w_p2 = (w_p1 < w_lo) ? w_lo : w_p1;
        priority if (w_p2 == '0) begin
            o_est_next = EW'(1);
        end else if (w_p2 > CW'(mapd_pkg::EST_MAX)) begin
            o_est_next = mapd_pkg::EST_MAX;
        end else begin
            o_est_next = w_p2[EW-1:0];
        end
    end

endmodule

// File: sv/mfm_adaptive_pll_decoder_core.sv
// Top level: MFM adaptive PLL data separator with an iterative shared divider.
// Flow: an accepted interval is divided twice by the shared divider (half-clock count, then
//   f / n), blended and updated; the first division is skipped when the preload already
//   shows an oversized count. Bits then follow at one bit per cycle for the n half-clocks
//   while the output is not stalled; a new interval is accepted only once back in idle.
// Reset (synchronous, active low): estimate 10240, nominal 20480, alpha 128, counter zero.
module mfm_adaptive_pll_decoder_core #(
    parameter int MAX_HALF_CLOCKS = mapd_pkg::MAX_HALF_CLOCKS_DEF,
    parameter int FLUX_BITS       = mapd_pkg::FLUX_BITS_DEF,
    parameter int FRAC_BITS       = mapd_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mapd_in_if.sink     i_in,
    mapd_out_if.source  o_out,
    mapd_cfg_if.sink    i_cfg
);

    localparam int EW    = mapd_pkg::EST_W;
    localparam int FW    = FLUX_BITS + FRAC_BITS;
    localparam int QB    = $clog2(MAX_HALF_CLOCKS + 1);
    localparam int NB    = QB;
    localparam int NW    = ((FW + 1 > EW) ? FW + 1 : EW) + 1;
    localparam int DW    = EW + 1;
    localparam int RW    = (NW - QB > DW) ? NW - QB : DW;
    localparam int CNT_W = $clog2(FW + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_DIV1,
        ST_DIV1_END,
        ST_DIV2,
        ST_BLEND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_steps, n_steps;
    logic [NB-1:0]                   r_n, n_n;
    logic [NB-1:0]                   r_k, n_k;
    logic [FW-1:0]                   r_f, n_f;
    logic [EW-1:0]                   r_est, n_est;
    logic [EW-1:0]                   r_nom, n_nom;
    logic [mapd_pkg::ALPHA_W-1:0]    r_alpha, n_alpha;
    logic [mapd_pkg::IDX_W-1:0]      r_cnt, n_cnt;
    logic [mapd_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic                            r_ov, n_ov;
    logic                            r_obit, n_obit;
    logic [mapd_pkg::IDX_W-1:0]      r_oidx, n_oidx;

    logic                            w_in_acc;
    logic                            w_cfg_acc;
    logic [FW-1:0]                   w_f;
    logic [NW-1:0]                   w_num;
    mapd_pkg::t_div_cmd              w_div_cmd;
    logic [RW-1:0]                   w_rem_load;
    logic [FW-1:0]                   w_shift_load;
    logic [DW-1:0]                   w_divisor;
    logic                            w_div_ge;
    logic [FW-1:0]                   w_quo;
    logic [NB-1:0]                   w_q1;
    logic [NB-1:0]                   w_n_val;
    logic [EW-1:0]                   w_blend_est;
    logic                            w_bit_last;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;

    assign o_out.valid          = r_ov;
    assign o_out.bit_res        = r_obit;
    assign o_out.last           = r_obit;
    assign o_out.interval_index = r_oidx;

    // Interval in Q form, and the rounding numerator 2f + e for the half-clock count
    assign w_f   = {i_in.flux_interval, {FRAC_BITS{1'b0}}};
    assign w_num = NW'({w_f, 1'b0}) + NW'(r_est);

    // Idle loads the half-clock division; otherwise the divider is reloaded with f / n.
    // Preloading N >> QB leaves QB quotient bits; a remainder not below 2e already
    // means the count is past MAX_HALF_CLOCKS.
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_rem_load   = RW'(w_num[NW-1:QB]);
            w_shift_load = {w_num[QB-1:0], {(FW-QB){1'b0}}};
        end else begin
            w_rem_load   = '0;
            w_shift_load = r_f;
        end
    end

    assign w_divisor = (r_state == ST_DIV2) ? DW'(r_n) : {r_est, 1'b0};

    mapd_divider #(
        .RW (RW),
        .FW (FW),
        .DW (DW)
    ) u_div (
        .i_clk        (i_clk),
        .i_cmd        (w_div_cmd),
        .i_rem_load   (w_rem_load),
        .i_shift_load (w_shift_load),
        .i_divisor    (w_divisor),
        .o_ge         (w_div_ge),
        .o_quo        (w_quo)
    );

    // The blend unit registers its products every cycle; they are valid in the cycle
    // after the second division settles
    mapd_blend #(
        .FW (FW)
    ) u_blend (
        .i_clk      (i_clk),
        .i_est      (r_est),
        .i_m        (w_quo),
        .i_alpha    (r_alpha),
        .o_est_next (w_blend_est)
    );

    // Half-clock count, saturated
    assign w_q1    = w_quo[NB-1:0];
    assign w_n_val = (w_q1 > NB'(MAX_HALF_CLOCKS)) ? NB'(MAX_HALF_CLOCKS) : w_q1;

    assign w_bit_last = (r_k == (r_n - NB'(1)));

    always_comb begin
        n_state   = r_state;
        n_steps   = r_steps;
        n_n       = r_n;
        n_k       = r_k;
        n_f       = r_f;
        n_est     = r_est;
        n_nom     = r_nom;
        n_alpha   = r_alpha;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_ov      = r_ov;
        n_obit    = r_obit;
        n_oidx    = r_oidx;
        w_div_cmd = mapd_pkg::DIV_HOLD;

        // Drop the shown item once taken
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_f       = w_f;
                    n_idx     = r_cnt;
                    n_cnt     = r_cnt + mapd_pkg::IDX_W'(1);
                    w_div_cmd = mapd_pkg::DIV_LOAD;
                    n_state   = ST_CHK;
                end
            end
            ST_CHK: begin
                if (w_div_ge) begin
                    n_n       = NB'(MAX_HALF_CLOCKS);
                    w_div_cmd = mapd_pkg::DIV_LOAD;
                    n_steps   = CNT_W'(FW);
                    n_state   = ST_DIV2;
                end else begin
                    n_steps = CNT_W'(QB);
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1: begin
                w_div_cmd = mapd_pkg::DIV_STEP;
                n_steps   = r_steps - CNT_W'(1);
                if (r_steps == CNT_W'(1)) begin
                    n_state = ST_DIV1_END;
                end
            end
            ST_DIV1_END: begin
                if (w_n_val == '0) begin
                    // no half-clock: leave the estimate alone
                    n_state = ST_IDLE;
                end else begin
                    n_n       = w_n_val;
                    w_div_cmd = mapd_pkg::DIV_LOAD;
                    n_steps   = CNT_W'(FW);
                    n_state   = ST_DIV2;
                end
            end
            ST_DIV2: begin
                w_div_cmd = mapd_pkg::DIV_STEP;
                n_steps   = r_steps - CNT_W'(1);
                if (r_steps == CNT_W'(1)) begin
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_est   = w_blend_est;
                n_k     = '0;
                // a single half-clock updates the estimate but yields no bits
                n_state = (r_n >= NB'(2)) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov   = 1'b1;
                    n_obit = w_bit_last;
                    n_oidx = r_idx;
                    n_k    = r_k + NB'(1);
                    if (w_bit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // The user must write configuration only while idle; the block does not enforce it. Unknown indexes are ignored
        if (w_cfg_acc) begin
            if (i_cfg.index == mapd_pkg::REG_NOMINAL) begin
                n_nom = i_cfg.data;
                n_est = mapd_pkg::est_from_nominal(i_cfg.data);
            end else if (i_cfg.index == mapd_pkg::REG_ALPHA) begin
                n_alpha = i_cfg.data[mapd_pkg::ALPHA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_steps <= '0;
            r_est   <= mapd_pkg::est_from_nominal(mapd_pkg::NOMINAL_RESET);
            r_nom   <= mapd_pkg::NOMINAL_RESET;
            r_alpha <= mapd_pkg::ALPHA_RESET;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
            r_est   <= n_est;
            r_nom   <= n_nom;
            r_alpha <= n_alpha;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_n    <= n_n;
        r_k    <= n_k;
        r_f    <= n_f;
        r_idx  <= n_idx;
        r_obit <= n_obit;
        r_oidx <= n_oidx;
    end

    // Bits are only produced for runs of two or more half-clocks, within the run length
    a_emit_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ((r_n >= NB'(2)) && (r_k < r_n)))
        else $error("emission outside a valid half-clock run");

    // The estimate never reaches zero, so the division never sees a zero divisor
    a_est_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_est != '0)
        else $error("half-clock estimate is zero");

    // An accepted interval keeps the input closed in the next cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in.ready)
        else $error("input ready straight after accepting an interval");

    // The count of half-clocks never exceeds its ceiling
    a_n_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV2) || (r_state == ST_EMIT)) |-> (r_n <= NB'(MAX_HALF_CLOCKS)))
        else $error("half-clock count above ceiling");

endmodule
